FILE: src/sdfg_pkg.sv
// ----------------------------------------------------------------------------
// sdfg_pkg
// Shared types and constants for the grouped signed decimal formatter.
// ----------------------------------------------------------------------------
package sdfg_pkg;

  localparam int MAG_WIDTH  = 64;
  localparam int NUM_DIGITS = 20;
  localparam int POS_WIDTH  = $clog2(NUM_DIGITS);
  localparam int GROUP_SIZE = 3;

  localparam logic [POS_WIDTH-1:0] POS_INIT = POS_WIDTH'(NUM_DIGITS - 1);
  localparam logic [1:0]           MOD_INIT = 2'((NUM_DIGITS - 1) % GROUP_SIZE);
  localparam logic [1:0]           MOD_LAST = 2'(GROUP_SIZE - 1);

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_DABBLE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

FILE: src/sdfg_bcd_cell.sv
// ----------------------------------------------------------------------------
// sdfg_bcd_cell
// One bcd digit of the conversion chain: add-3-and-shift during conversion,
// digit shift toward the top while characters are emitted.
// ----------------------------------------------------------------------------
module sdfg_bcd_cell (
  input  logic                clk,
  input  sdfg_pkg::cell_ctrl_t ctrl,
  input  logic                bit_in,
  input  logic [3:0]          digit_in,
  output logic                bit_out,
  output logic [3:0]          digit
);

  logic [3:0] adj;

  assign adj     = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign bit_out = adj[3];

  always_ff @(posedge clk) begin
    case (ctrl.op)
      sdfg_pkg::OP_CLEAR:  digit <= 4'd0;
      sdfg_pkg::OP_DABBLE: digit <= {adj[2:0], bit_in};
      sdfg_pkg::OP_SHIFT:  digit <= digit_in;
      default:             digit <= digit;
    endcase
  end

endmodule

FILE: src/signed_decimal_formatter_grouped.sv
// ----------------------------------------------------------------------------
// signed_decimal_formatter_grouped
// Signed 64-bit integer to grouped decimal ascii text, one character a beat.
// ----------------------------------------------------------------------------
// Input channel: value with in_valid / in_stall. One beat is one number.
// Output channel: character and final_char with out_valid / out_stall. Each
// number gives 1 to 26 beats, most significant first: an optional '-', the
// digits with ',' between groups of three, final_char set on the last one.
// The magnitude is shifted into a row of 20 bcd digit cells, one bit per
// cycle. The same row then shifts digits toward the top cell: leading zeros
// are dropped first, and each character is emitted while the receiver is
// not stalling. One number is in work at a time. in_stall is low only while
// no number is in work; the last character may still sit in the output
// register when the next beat is taken.
// A stall holds the output register and freezes the emit sequence.
// Synchronous reset returns to idle and drops any pending output beat.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_grouped (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [63:0] value,
  input  logic               in_valid,
  output logic               in_stall,
  output logic [7:0]         character,
  output logic               final_char,
  output logic               out_valid,
  input  logic               out_stall
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT,
    ST_COMMA
  } state_t;

  state_t                              state;
  logic                                neg;
  logic [sdfg_pkg::MAG_WIDTH-1:0]      mag;
  logic [5:0]                          cnt;
  logic [sdfg_pkg::POS_WIDTH-1:0]      pos;
  logic [1:0]                          mod3;
  logic [1:0]                          mod3_next;
  logic                                accept;
  logic                                out_free;
  logic                                emit;
  logic [3:0]                          top;
  sdfg_pkg::cell_ctrl_t                cell_ctrl;

  logic [3:0]                          digits [sdfg_pkg::NUM_DIGITS];
  logic                                chain  [sdfg_pkg::NUM_DIGITS+1];

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit      = out_free && (state == ST_SIGN || state == ST_DIGIT || state == ST_COMMA);
  assign top       = digits[sdfg_pkg::NUM_DIGITS-1];
  assign mod3_next = (mod3 == 2'd0) ? sdfg_pkg::MOD_LAST : (mod3 - 2'd1);
  assign chain[0]  = mag[sdfg_pkg::MAG_WIDTH-1];

  genvar i;
  generate
    for (i = 0; i < sdfg_pkg::NUM_DIGITS; i++) begin : g_cell
      logic [3:0] low_digit;
      if (i == 0) begin : g_first
        assign low_digit = 4'd0;
      end else begin : g_rest
        assign low_digit = digits[i-1];
      end
      sdfg_bcd_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .bit_in   (chain[i]),
        .digit_in (low_digit),
        .bit_out  (chain[i+1]),
        .digit    (digits[i])
      );
    end
  endgenerate

  always_comb begin
    cell_ctrl.op = sdfg_pkg::OP_HOLD;
    case (state)
      ST_IDLE:  if (accept) cell_ctrl.op = sdfg_pkg::OP_CLEAR;
      ST_CONV:  cell_ctrl.op = sdfg_pkg::OP_DABBLE;
      ST_SKIP:  if (pos != '0 && top == 4'd0) cell_ctrl.op = sdfg_pkg::OP_SHIFT;
      ST_DIGIT: if (out_free) cell_ctrl.op = sdfg_pkg::OP_SHIFT;
      default:  cell_ctrl.op = sdfg_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            neg   <= value[63];
            mag   <= value[63] ? (~$unsigned(value) + 64'd1) : $unsigned(value);
            cnt   <= '0;
            pos   <= sdfg_pkg::POS_INIT;
            mod3  <= sdfg_pkg::MOD_INIT;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag <= {mag[sdfg_pkg::MAG_WIDTH-2:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == '1) begin
            state <= neg ? ST_SIGN : ST_SKIP;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            character  <= sdfg_pkg::CHAR_MINUS;
            final_char <= 1'b0;
            state      <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, but always keep the units digit
          if (pos != '0 && top == 4'd0) begin
            pos  <= pos - 1'b1;
            mod3 <= mod3_next;
          end else begin
            state <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            character  <= sdfg_pkg::CHAR_ZERO + {4'd0, top};
            final_char <= (pos == '0);
            if (pos == '0) begin
              state <= ST_IDLE;
            end else begin
              pos  <= pos - 1'b1;
              mod3 <= mod3_next;
              if (mod3 == 2'd0) begin
                state <= ST_COMMA;
              end
            end
          end
        end
        ST_COMMA: begin
          if (out_free) begin
            character  <= sdfg_pkg::CHAR_COMMA;
            final_char <= 1'b0;
            state      <= ST_DIGIT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // bit counter only runs during conversion
  a_cnt_conv: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (state == ST_CONV))
    else $error("bit counter running outside conversion");

  // 20 digits always hold a 64-bit magnitude
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !chain[sdfg_pkg::NUM_DIGITS])
    else $error("bcd chain overflow");

  a_comma_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == sdfg_pkg::CHAR_COMMA) |-> !final_char)
    else $error("separator flagged as last character");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_char) |->
      (character >= sdfg_pkg::CHAR_ZERO && character <= sdfg_pkg::CHAR_NINE))
    else $error("last character is not a digit");

  a_units_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGIT && pos == '0 && out_free) |=> (state == ST_IDLE && final_char))
    else $error("units digit did not end the number");

endmodule
